FILE: rtl/dcf77_ptd_pkg.sv
// ----------------------------------------------------------------------------
// dcf77_ptd_pkg
// Types, codes and constants shared by the DCF77 pulse time decoder.
// ----------------------------------------------------------------------------
package dcf77_ptd_pkg;

  localparam int TIME_W    = 16;
  localparam int CFG_IDX_W = 8;
  localparam int CFG_COUNT = 8;
  localparam int CFG_SEL_W = $clog2(CFG_COUNT);

  localparam logic [TIME_W-1:0] LONG_GAP_MAX_DEFAULT = 16'd930;
  localparam logic [TIME_W-1:0] SPIKE_LIMIT          = 16'd2;

  // Register indexes on the configuration port
  typedef enum logic [CFG_SEL_W-1:0] {
    CFG_SYNC_GAP        = 3'd0,
    CFG_SHORT_PULSE_MIN = 3'd1,
    CFG_SHORT_PULSE_MAX = 3'd2,
    CFG_LONG_PULSE_MIN  = 3'd3,
    CFG_LONG_PULSE_MAX  = 3'd4,
    CFG_SHORT_GAP_MIN   = 3'd5,
    CFG_SHORT_GAP_MAX   = 3'd6,
    CFG_LONG_GAP_MIN    = 3'd7
  } cfg_sel_t;

  localparam logic [TIME_W-1:0] RST_SYNC_GAP        = 16'd1500;
  localparam logic [TIME_W-1:0] RST_SHORT_PULSE_MIN = 16'd70;
  localparam logic [TIME_W-1:0] RST_SHORT_PULSE_MAX = 16'd130;
  localparam logic [TIME_W-1:0] RST_LONG_PULSE_MIN  = 16'd170;
  localparam logic [TIME_W-1:0] RST_LONG_PULSE_MAX  = 16'd230;
  localparam logic [TIME_W-1:0] RST_SHORT_GAP_MIN   = 16'd770;
  localparam logic [TIME_W-1:0] RST_SHORT_GAP_MAX   = 16'd830;
  localparam logic [TIME_W-1:0] RST_LONG_GAP_MIN    = 16'd870;

  typedef struct packed {
    logic [TIME_W-1:0] sync_gap;
    logic [TIME_W-1:0] short_pulse_min;
    logic [TIME_W-1:0] short_pulse_max;
    logic [TIME_W-1:0] long_pulse_min;
    logic [TIME_W-1:0] long_pulse_max;
    logic [TIME_W-1:0] short_gap_min;
    logic [TIME_W-1:0] short_gap_max;
    logic [TIME_W-1:0] long_gap_min;
  } thr_t;

  typedef enum logic [2:0] {
    CLS_SPIKE       = 3'd0,
    CLS_SHORT_PULSE = 3'd1,
    CLS_LONG_PULSE  = 3'd2,
    CLS_SHORT_GAP   = 3'd3,
    CLS_LONG_GAP    = 3'd4,
    CLS_SYNC        = 3'd5,
    CLS_INVALID     = 3'd6
  } cls_t;

  typedef enum logic [3:0] {
    ERR_NONE             = 4'd0,
    ERR_SHORT_PAIR       = 4'd1,
    ERR_LONG_PAIR        = 4'd2,
    ERR_MARKER           = 4'd3,
    ERR_BELOW_SHORT      = 4'd4,
    ERR_BETWEEN_PULSES   = 4'd5,
    ERR_BEFORE_SHORT_GAP = 4'd6,
    ERR_BETWEEN_GAPS     = 4'd7,
    ERR_ABOVE_LONG_GAP   = 4'd8
  } err_t;

  typedef enum logic [2:0] {
    PAIR_IDLE        = 3'd0,
    PAIR_SHORT_PULSE = 3'd1,
    PAIR_LONG_PULSE  = 3'd2,
    PAIR_SHORT_GAP   = 3'd3,
    PAIR_LONG_GAP    = 3'd4
  } pair_t;

  typedef enum logic [2:0] {
    FLD_NONE    = 3'd0,
    FLD_MINUTE  = 3'd1,
    FLD_HOUR    = 3'd2,
    FLD_DAY     = 3'd3,
    FLD_WEEKDAY = 3'd4,
    FLD_MONTH   = 3'd5,
    FLD_YEAR    = 3'd6
  } fld_t;

  // Bit positions within the minute frame
  localparam logic [7:0] BIT_IDLE      = 8'd255;
  localparam logic [7:0] BIT_HOLD      = 8'd254;
  localparam logic [7:0] BIT_MARKER    = 8'd20;
  localparam logic [7:0] BIT_MIN_PAR   = 8'd28;
  localparam logic [7:0] BIT_HOUR_PAR  = 8'd35;
  localparam logic [7:0] BIT_DAY_END   = 8'd41;
  localparam logic [7:0] BIT_WDAY_END  = 8'd44;
  localparam logic [7:0] BIT_MONTH_END = 8'd49;
  localparam logic [7:0] BIT_YEAR_END  = 8'd57;

  typedef struct packed {
    cls_t       interval_class;
    err_t       error_code;
    logic       bit_valid;
    logic       bit_value;
    fld_t       field_id;
    logic [7:0] field_value;
    logic       parity_fail;
    logic       time_valid;
    logic [6:0] minute;
    logic [5:0] hour;
  } res_t;

  // BCD weight of the k-th bit of a field
  function automatic logic [7:0] weight_of(input logic [2:0] step);
    logic [7:0] w;
    case (step)
      3'd0:    w = 8'd1;
      3'd1:    w = 8'd2;
      3'd2:    w = 8'd4;
      3'd3:    w = 8'd8;
      3'd4:    w = 8'd10;
      3'd5:    w = 8'd20;
      3'd6:    w = 8'd40;
      default: w = 8'd80;
    endcase
    return w;
  endfunction

endpackage

FILE: rtl/dcf77_ptd_cfg.sv
// ----------------------------------------------------------------------------
// dcf77_ptd_cfg
// Threshold register file written through the configuration channel.
// ----------------------------------------------------------------------------
module dcf77_ptd_cfg (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [dcf77_ptd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [dcf77_ptd_pkg::TIME_W-1:0]      cfg_data,
  output dcf77_ptd_pkg::thr_t                   thr
);
  import dcf77_ptd_pkg::*;

  logic [TIME_W-1:0] regs [CFG_COUNT];
  logic              wr_en;

  assign cfg_ready = 1'b1;
  assign wr_en     = cfg_valid && (cfg_index < CFG_IDX_W'(CFG_COUNT));

  always_ff @(posedge clk) begin
    if (rst) begin
      regs[CFG_SYNC_GAP]        <= RST_SYNC_GAP;
      regs[CFG_SHORT_PULSE_MIN] <= RST_SHORT_PULSE_MIN;
      regs[CFG_SHORT_PULSE_MAX] <= RST_SHORT_PULSE_MAX;
      regs[CFG_LONG_PULSE_MIN]  <= RST_LONG_PULSE_MIN;
      regs[CFG_LONG_PULSE_MAX]  <= RST_LONG_PULSE_MAX;
      regs[CFG_SHORT_GAP_MIN]   <= RST_SHORT_GAP_MIN;
      regs[CFG_SHORT_GAP_MAX]   <= RST_SHORT_GAP_MAX;
      regs[CFG_LONG_GAP_MIN]    <= RST_LONG_GAP_MIN;
    end else if (wr_en) begin
      regs[cfg_index[CFG_SEL_W-1:0]] <= cfg_data;
    end
  end

  assign thr.sync_gap        = regs[CFG_SYNC_GAP];
  assign thr.short_pulse_min = regs[CFG_SHORT_PULSE_MIN];
  assign thr.short_pulse_max = regs[CFG_SHORT_PULSE_MAX];
  assign thr.long_pulse_min  = regs[CFG_LONG_PULSE_MIN];
  assign thr.long_pulse_max  = regs[CFG_LONG_PULSE_MAX];
  assign thr.short_gap_min   = regs[CFG_SHORT_GAP_MIN];
  assign thr.short_gap_max   = regs[CFG_SHORT_GAP_MAX];
  assign thr.long_gap_min    = regs[CFG_LONG_GAP_MIN];

endmodule

FILE: rtl/dcf77_ptd_classify.sv
// ----------------------------------------------------------------------------
// dcf77_ptd_classify
// Sorts an edge interval into a class through the ordered window chain.
// ----------------------------------------------------------------------------
module dcf77_ptd_classify #(
  parameter logic [dcf77_ptd_pkg::TIME_W-1:0] LONG_GAP_MAX =
    dcf77_ptd_pkg::LONG_GAP_MAX_DEFAULT
) (
  input  logic [dcf77_ptd_pkg::TIME_W-1:0] interval,
  input  dcf77_ptd_pkg::thr_t              thr,
  output dcf77_ptd_pkg::cls_t              cls,
  output dcf77_ptd_pkg::err_t              err
);
  import dcf77_ptd_pkg::*;

  // First matching window wins
  always_comb begin
    cls = CLS_INVALID;
    err = ERR_NONE;
    if (interval > thr.sync_gap) begin
      cls = CLS_SYNC;
    end else if (interval < SPIKE_LIMIT) begin
      cls = CLS_SPIKE;
    end else if (interval < thr.short_pulse_min) begin
      err = ERR_BELOW_SHORT;
    end else if (interval < thr.short_pulse_max) begin
      cls = CLS_SHORT_PULSE;
    end else if (interval < thr.long_pulse_min) begin
      err = ERR_BETWEEN_PULSES;
    end else if (interval < thr.long_pulse_max) begin
      cls = CLS_LONG_PULSE;
    end else if (interval < thr.short_gap_min) begin
      err = ERR_BEFORE_SHORT_GAP;
    end else if (interval < thr.short_gap_max) begin
      cls = CLS_SHORT_GAP;
    end else if (interval < thr.long_gap_min) begin
      err = ERR_BETWEEN_GAPS;
    end else if (interval < LONG_GAP_MAX) begin
      cls = CLS_LONG_GAP;
    end else begin
      err = ERR_ABOVE_LONG_GAP;
    end
  end

endmodule

FILE: rtl/dcf77_ptd_frame.sv
// ----------------------------------------------------------------------------
// dcf77_ptd_frame
// Frame state: pulse/gap pairing, bit counter, BCD field accumulation,
// parity check and minute/hour latching.
// ----------------------------------------------------------------------------
module dcf77_ptd_frame #(
  parameter logic [dcf77_ptd_pkg::TIME_W-1:0] LONG_GAP_MAX =
    dcf77_ptd_pkg::LONG_GAP_MAX_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              fire,
  input  logic [dcf77_ptd_pkg::TIME_W-1:0]  edge_time,
  input  dcf77_ptd_pkg::thr_t               thr,
  output dcf77_ptd_pkg::res_t               res
);
  import dcf77_ptd_pkg::*;

  logic [TIME_W-1:0] last_edge;
  pair_t             pair_state, pair_next;
  logic [7:0]        bit_count, bit_count_next;
  err_t              frame_error, frame_error_next;
  logic [7:0]        field_acc, field_acc_next;
  logic [2:0]        weight_step, weight_step_next;
  logic              parity_acc, parity_acc_next;
  logic [6:0]        minute_pending, minute_pending_next;
  logic [5:0]        hour_pending, hour_pending_next;
  logic [6:0]        minute_latched, minute_latched_next;
  logic [5:0]        hour_latched, hour_latched_next;

  logic [TIME_W-1:0] interval;
  cls_t              cls;
  err_t              cls_err;
  logic              is_pair_cls;
  logic              take;
  logic              bit_b;
  err_t              pair_err;
  logic [7:0]        n;
  logic [7:0]        acc_sum;

  assign interval = edge_time - last_edge;

  dcf77_ptd_classify #(
    .LONG_GAP_MAX (LONG_GAP_MAX)
  ) u_classify (
    .interval (interval),
    .thr      (thr),
    .cls      (cls),
    .err      (cls_err)
  );

  assign is_pair_cls = (cls == CLS_SHORT_PULSE) || (cls == CLS_LONG_PULSE) ||
                       (cls == CLS_SHORT_GAP) || (cls == CLS_LONG_GAP);
  assign bit_b       = (pair_state == PAIR_LONG_PULSE);

  // Pairing: a pulse must be followed by its matching gap
  always_comb begin
    take     = 1'b0;
    pair_err = ERR_NONE;
    if (is_pair_cls) begin
      if (pair_state == PAIR_SHORT_PULSE) begin
        if (cls == CLS_LONG_GAP) take = 1'b1;
        else pair_err = ERR_SHORT_PAIR;
      end else if (pair_state == PAIR_LONG_PULSE) begin
        if (cls == CLS_SHORT_GAP) take = 1'b1;
        else pair_err = ERR_LONG_PAIR;
      end
    end
  end

  // Pairing state: next state
  always_comb begin
    pair_next = pair_state;
    unique case (cls)
      CLS_SYNC:        pair_next = PAIR_IDLE;
      CLS_SHORT_PULSE: pair_next = PAIR_SHORT_PULSE;
      CLS_LONG_PULSE:  pair_next = PAIR_LONG_PULSE;
      CLS_SHORT_GAP:   pair_next = PAIR_SHORT_GAP;
      CLS_LONG_GAP:    pair_next = PAIR_LONG_GAP;
      default:         pair_next = pair_state;
    endcase
  end

  always_comb begin
    if (bit_count == BIT_IDLE) n = 8'd0;
    else if (bit_count < BIT_HOLD) n = bit_count + 8'd1;
    else n = bit_count;
  end

  assign acc_sum = field_acc + (bit_b ? weight_of(weight_step) : 8'd0);

  // Frame datapath and result
  always_comb begin
    bit_count_next      = bit_count;
    frame_error_next    = frame_error;
    field_acc_next      = field_acc;
    weight_step_next    = weight_step;
    parity_acc_next     = parity_acc;
    minute_pending_next = minute_pending;
    hour_pending_next   = hour_pending;
    minute_latched_next = minute_latched;
    hour_latched_next   = hour_latched;

    res                = '0;
    res.interval_class = cls;
    res.error_code     = cls_err;

    if (cls_err != ERR_NONE) frame_error_next = cls_err;

    if (cls == CLS_SYNC) begin
      if (frame_error == ERR_NONE) begin
        res.time_valid      = 1'b1;
        minute_latched_next = minute_pending;
        hour_latched_next   = hour_pending;
      end
      bit_count_next   = BIT_IDLE;
      frame_error_next = ERR_NONE;
      weight_step_next = 3'd0;
    end

    if (pair_err != ERR_NONE) begin
      res.error_code   = pair_err;
      frame_error_next = pair_err;
    end

    if (take) begin
      res.bit_valid  = 1'b1;
      res.bit_value  = bit_b;
      bit_count_next = n;
      if (n >= BIT_MARKER && n <= BIT_YEAR_END) begin
        if (n == BIT_MARKER) begin
          if (!bit_b) begin
            res.error_code   = ERR_MARKER;
            frame_error_next = ERR_MARKER;
          end
          field_acc_next   = 8'd0;
          weight_step_next = 3'd0;
          parity_acc_next  = 1'b0;
        end else if (n == BIT_MIN_PAR || n == BIT_HOUR_PAR) begin
          res.parity_fail = (bit_b != parity_acc);
          if (frame_error == ERR_NONE) begin
            if (n == BIT_MIN_PAR) minute_pending_next = field_acc[6:0];
            else hour_pending_next = field_acc[5:0];
            res.field_id    = (n == BIT_MIN_PAR) ? FLD_MINUTE : FLD_HOUR;
            res.field_value = field_acc;
          end
          field_acc_next   = 8'd0;
          weight_step_next = 3'd0;
          parity_acc_next  = 1'b0;
        end else if (n == BIT_DAY_END || n == BIT_WDAY_END ||
                     n == BIT_MONTH_END || n == BIT_YEAR_END) begin
          if (frame_error == ERR_NONE) begin
            if (n == BIT_DAY_END) res.field_id = FLD_DAY;
            else if (n == BIT_WDAY_END) res.field_id = FLD_WEEKDAY;
            else if (n == BIT_MONTH_END) res.field_id = FLD_MONTH;
            else res.field_id = FLD_YEAR;
            res.field_value = acc_sum;
          end
          field_acc_next   = 8'd0;
          weight_step_next = 3'd0;
          parity_acc_next  = 1'b0;
        end else begin
          field_acc_next   = acc_sum;
          parity_acc_next  = parity_acc ^ bit_b;
          weight_step_next = weight_step + 3'd1;
        end
      end
    end

    res.minute = minute_latched_next;
    res.hour   = hour_latched_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_edge      <= '0;
      pair_state     <= PAIR_IDLE;
      bit_count      <= BIT_IDLE;
      frame_error    <= ERR_NONE;
      field_acc      <= '0;
      weight_step    <= '0;
      parity_acc     <= 1'b0;
      minute_pending <= '0;
      hour_pending   <= '0;
      minute_latched <= '0;
      hour_latched   <= '0;
    end else if (fire) begin
      last_edge      <= edge_time;
      pair_state     <= pair_next;
      bit_count      <= bit_count_next;
      frame_error    <= frame_error_next;
      field_acc      <= field_acc_next;
      weight_step    <= weight_step_next;
      parity_acc     <= parity_acc_next;
      minute_pending <= minute_pending_next;
      hour_pending   <= hour_pending_next;
      minute_latched <= minute_latched_next;
      hour_latched   <= hour_latched_next;
    end
  end

`ifndef SYNTH
  a_sync_restarts_frame: assert property (@(posedge clk) disable iff (rst)
    fire && cls == CLS_SYNC |=> bit_count == BIT_IDLE && frame_error == ERR_NONE
      && pair_state == PAIR_IDLE)
    else $error("sync did not restart the frame");

  a_field_only_clean: assert property (@(posedge clk) disable iff (rst)
    res.field_id != FLD_NONE |-> frame_error == ERR_NONE && take)
    else $error("field reported with a recorded error");

  a_bit_needs_pair: assert property (@(posedge clk) disable iff (rst)
    res.bit_valid |-> (pair_state == PAIR_SHORT_PULSE || pair_state == PAIR_LONG_PULSE)
      && res.error_code != ERR_SHORT_PAIR && res.error_code != ERR_LONG_PAIR)
    else $error("data bit without a matching pulse and gap");

  a_time_valid_on_sync: assert property (@(posedge clk) disable iff (rst)
    res.time_valid |-> res.interval_class == CLS_SYNC)
    else $error("time_valid outside a sync edge");
`endif

endmodule

FILE: rtl/dcf77_pulse_time_decoder.sv
// ----------------------------------------------------------------------------
// dcf77_pulse_time_decoder
// DCF77 pulse timing decoder: edge timestamps in, decoded bits and time out.
// ----------------------------------------------------------------------------
// Each transaction on the input channel carries the millisecond time of one
// edge; each produces exactly one result transaction. The block takes one edge
// per clock cycle unless the output stalls; the edge time is captured in an
// input register, classified and folded into the frame state in one pass,
// and the result is held in an output register, so a new edge is accepted
// while the previous result still waits. Threshold registers are written
// through the configuration channel (always ready, indexes beyond the
// register list are ignored) and take effect from the next cycle; write them
// only while no edge is in flight. No clearing pass is needed after reset.
module dcf77_pulse_time_decoder #(
  parameter logic [dcf77_ptd_pkg::TIME_W-1:0] LONG_GAP_MAX =
    dcf77_ptd_pkg::LONG_GAP_MAX_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [dcf77_ptd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [dcf77_ptd_pkg::TIME_W-1:0]    cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [dcf77_ptd_pkg::TIME_W-1:0]    edge_time_ms,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [2:0]                          interval_class,
  output logic [3:0]                          error_code,
  output logic                                bit_valid,
  output logic                                bit_value,
  output logic [2:0]                          field_id,
  output logic [7:0]                          field_value,
  output logic                                parity_fail,
  output logic                                time_valid,
  output logic [6:0]                          minute,
  output logic [5:0]                          hour
);
  import dcf77_ptd_pkg::*;

  thr_t              thr;
  logic              s1_valid;
  logic [TIME_W-1:0] s1_time;
  logic              advance;
  res_t              res;
  res_t              out_res;

  dcf77_ptd_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .thr       (thr)
  );

  // Move the captured edge into the result register when there is room
  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_time <= edge_time_ms;
    end
  end

  dcf77_ptd_frame #(
    .LONG_GAP_MAX (LONG_GAP_MAX)
  ) u_frame (
    .clk       (clk),
    .rst       (rst),
    .fire      (advance),
    .edge_time (s1_time),
    .thr       (thr),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= res;
    end
  end

  assign interval_class = out_res.interval_class;
  assign error_code     = out_res.error_code;
  assign bit_valid      = out_res.bit_valid;
  assign bit_value      = out_res.bit_value;
  assign field_id       = out_res.field_id;
  assign field_value    = out_res.field_value;
  assign parity_fail    = out_res.parity_fail;
  assign time_valid     = out_res.time_valid;
  assign minute         = out_res.minute;
  assign hour           = out_res.hour;

endmodule
